/* rtl/rpn_pkg.sv */
// Package for the RPN stack calculator: command and status codes, and the
// control bundle that the top level sends to the bit-serial arithmetic unit.
// Depends on nothing; the top level and rpn_muldiv use it.
package rpn_pkg;

  typedef enum logic [3:0] {
    CMD_PUSH  = 4'd0,
    CMD_ADD   = 4'd1,
    CMD_SUB   = 4'd2,
    CMD_MUL   = 4'd3,
    CMD_DIV   = 4'd4,
    CMD_MOD   = 4'd5,
    CMD_POP   = 4'd6,
    CMD_PEEK  = 4'd7,
    CMD_SWAP  = 4'd8,
    CMD_CLEAR = 4'd9
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_UNDER = 3'd1,
    ST_FULL  = 3'd2,
    ST_ZDIV  = 3'd3,
    ST_SWAP  = 3'd4,
    ST_SAT   = 3'd5
  } status_t;

  // start: load operands and begin; div: divide rather than multiply;
  // whole: the dividend is an integer and is not shifted by the fraction bits.
  typedef struct packed {
    logic start;
    logic div;
    logic whole;
  } md_ctrl_t;

endpackage

/* rtl/rpn_stack_calculator.sv */
// Top level of the RPN stack calculator: command sequencer, stack pointer,
// saturation and status logic. Depends on rpn_pkg, rpn_stack_mem, rpn_muldiv.
//
//  Channel | Direction | tdata fields (lowest bit up)                 | tuser
//  in_     | slave     | command[3:0], operand[VW-1:0], zero pad      | none
//  out_    | master    | value[VW-1:0], status[2:0], depth[CW-1:0], pad | none
//
// Each transaction takes a set sequence: two stack reads, one execute step,
// a write-back step (two for swap) and an output step. Multiply, divide and
// modulo also wait on the bit-serial unit after the execute step, which then
// sets the rate at which those transactions are taken.
// Reset clears the sequencer, the depth and the output valid; stack entries
// are not cleared, since only entries below the depth are ever read.
// A new transaction is taken while a result still waits downstream; its own
// result is held back until the output register is free.
module rpn_stack_calculator #(
  parameter int STACK_DEPTH = 128,
  parameter int VALUE_WIDTH = 32
) (
  input  logic clk,
  input  logic rst_n,
  input  logic                                         in_tvalid,
  output logic                                         in_tready,
  // command[3:0], operand[VALUE_WIDTH+3:4], zero pad above
  input  logic [((4+VALUE_WIDTH+7)/8)*8-1:0]           in_tdata,
  output logic                                         out_tvalid,
  input  logic                                         out_tready,
  // value[VW-1:0], status[VW+2:VW], depth above it, zero pad above
  output logic [((VALUE_WIDTH+3+$clog2(STACK_DEPTH+1)+7)/8)*8-1:0] out_tdata
);

  localparam int VW    = VALUE_WIDTH;
  localparam int F     = VW / 2;
  localparam int QW    = VW + F;
  localparam int CW    = $clog2(STACK_DEPTH + 1);
  localparam int AW    = $clog2(STACK_DEPTH);
  localparam int OUT_W = ((VW + 3 + CW + 7) / 8) * 8;

  localparam logic [VW-1:0] SIGN_V = {1'b1, {(VW-1){1'b0}}};
  localparam logic [VW-1:0] MAXP_V = {1'b0, {(VW-1){1'b1}}};

  // Sequencer states.
  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_RDB  = 9'b000000010,
    S_RDA  = 9'b000000100,
    S_GETA = 9'b000001000,
    S_EXEC = 9'b000010000,
    S_RUN  = 9'b000100000,
    S_WR   = 9'b001000000,
    S_WR2  = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  logic [3:0]    cmd_r, cmd_nxt;
  logic [VW-1:0] opnd_r, opnd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [VW-1:0] b_r, b_nxt, a_r, a_nxt;
  logic [VW-1:0] val_r, val_nxt;
  logic [2:0]    sts_r, sts_nxt;
  logic [CW-1:0] ncnt_r, ncnt_nxt;
  logic          wen_r, wen_nxt;
  logic [AW-1:0] waddr_r, waddr_nxt;
  logic          swap_r, swap_nxt;
  logic          neg_r, neg_nxt;
  logic          mod_r, mod_nxt;
  logic          under_r, under_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [VW-1:0] out_value_r, out_value_nxt;
  logic [2:0]    out_status_r, out_status_nxt;
  logic [CW-1:0] out_depth_r, out_depth_nxt;

  logic [CW-1:0] top_idx, sec_idx, pop1_cnt, pop2_cnt;
  logic          has1, has2;
  logic [VW-1:0] mag_a, mag_b, addsub, rdata, mem_wdata;
  logic          ovf, same;
  logic [AW-1:0] raddr, mem_waddr;
  logic          mem_we;

  rpn_pkg::md_ctrl_t md_ctrl;
  logic [VW-1:0]     md_opa, md_opb, md_rem;
  logic [QW-1:0]     md_q, fin_q;
  logic              md_done;
  logic              satp, satn, fin_sat;
  logic [VW-1:0]     fin_val;

  assign top_idx  = cnt_r - CW'(1);
  assign sec_idx  = cnt_r - CW'(2);
  assign has1     = (cnt_r != '0);
  assign has2     = (cnt_r > CW'(1));
  assign pop1_cnt = has1 ? top_idx : '0;
  assign pop2_cnt = has2 ? sec_idx : '0;
  assign mag_a    = a_r[VW-1] ? (VW'(0) - a_r) : a_r;
  assign mag_b    = b_r[VW-1] ? (VW'(0) - b_r) : b_r;

  // Saturating add and subtract.
  always_comb begin
    addsub = (cmd_r == rpn_pkg::CMD_SUB) ? (a_r - b_r) : (a_r + b_r);
    same   = (a_r[VW-1] == b_r[VW-1]);
    ovf    = ((cmd_r == rpn_pkg::CMD_SUB) ? !same : same) && (addsub[VW-1] != a_r[VW-1]);
  end

  // Sign and saturation of a magnitude result from the serial unit.
  always_comb begin
    fin_q   = mod_r ? {md_rem, {F{1'b0}}} : md_q;
    satp    = |fin_q[QW-1:VW-1];
    satn    = (|fin_q[QW-1:VW]) || (fin_q[VW-1] && (|fin_q[VW-2:0]));
    fin_sat = neg_r ? satn : satp;
    if (neg_r) begin
      fin_val = satn ? SIGN_V : (VW'(0) - fin_q[VW-1:0]);
    end else begin
      fin_val = satp ? MAXP_V : fin_q[VW-1:0];
    end
  end

  assign raddr     = (state_r == S_RDA) ? sec_idx[AW-1:0] : top_idx[AW-1:0];
  assign mem_we    = ((state_r == S_WR) && wen_r) || (state_r == S_WR2);
  assign mem_waddr = (state_r == S_WR2) ? sec_idx[AW-1:0] : waddr_r;
  assign mem_wdata = (state_r == S_WR2) ? b_r : val_r;

  rpn_stack_mem #(
    .DEPTH (STACK_DEPTH),
    .W     (VW),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  rpn_muldiv #(
    .VW (VW)
  ) u_md (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (md_ctrl),
    .opa   (md_opa),
    .opb   (md_opb),
    .done  (md_done),
    .q     (md_q),
    .rem   (md_rem)
  );

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    opnd_nxt       = opnd_r;
    cnt_nxt        = cnt_r;
    b_nxt          = b_r;
    a_nxt          = a_r;
    val_nxt        = val_r;
    sts_nxt        = sts_r;
    ncnt_nxt       = ncnt_r;
    wen_nxt        = wen_r;
    waddr_nxt      = waddr_r;
    swap_nxt       = swap_r;
    neg_nxt        = neg_r;
    mod_nxt        = mod_r;
    under_nxt      = under_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_depth_nxt  = out_depth_r;
    md_ctrl        = '0;
    md_opa         = mag_a;
    md_opb         = mag_b;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt   = in_tdata[3:0];
          opnd_nxt  = in_tdata[VW+3:4];
          state_nxt = S_RDB;
        end
      end
      S_RDB: begin
        state_nxt = S_RDA;
      end
      S_RDA: begin
        b_nxt     = has1 ? rdata : '0;
        state_nxt = S_GETA;
      end
      S_GETA: begin
        a_nxt     = has2 ? rdata : '0;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        // Defaults: nothing written, depth unchanged, value zero, status ok.
        val_nxt   = '0;
        sts_nxt   = rpn_pkg::ST_OK;
        ncnt_nxt  = cnt_r;
        wen_nxt   = 1'b0;
        waddr_nxt = pop2_cnt[AW-1:0];
        swap_nxt  = 1'b0;
        under_nxt = !has2;
        neg_nxt   = a_r[VW-1] ^ b_r[VW-1];
        mod_nxt   = 1'b0;
        state_nxt = S_WR;
        case (cmd_r)
          rpn_pkg::CMD_PUSH: begin
            if (cnt_r < CW'(STACK_DEPTH)) begin
              val_nxt   = opnd_r;
              wen_nxt   = 1'b1;
              waddr_nxt = cnt_r[AW-1:0];
              ncnt_nxt  = cnt_r + CW'(1);
            end else begin
              sts_nxt = rpn_pkg::ST_FULL;
            end
          end
          rpn_pkg::CMD_ADD, rpn_pkg::CMD_SUB: begin
            val_nxt  = ovf ? (a_r[VW-1] ? SIGN_V : MAXP_V) : addsub;
            wen_nxt  = 1'b1;
            ncnt_nxt = pop2_cnt + CW'(1);
            sts_nxt  = !has2 ? rpn_pkg::ST_UNDER : (ovf ? rpn_pkg::ST_SAT : rpn_pkg::ST_OK);
          end
          rpn_pkg::CMD_MUL: begin
            wen_nxt      = 1'b1;
            ncnt_nxt     = pop2_cnt + CW'(1);
            md_ctrl.start = 1'b1;
            state_nxt    = S_RUN;
          end
          rpn_pkg::CMD_DIV, rpn_pkg::CMD_MOD: begin
            if ((cmd_r == rpn_pkg::CMD_DIV && b_r == '0) ||
                (cmd_r == rpn_pkg::CMD_MOD && mag_b[VW-1:F] == '0)) begin
              // Divisor gone, dividend stays, nothing pushed.
              ncnt_nxt = pop1_cnt;
              sts_nxt  = has1 ? rpn_pkg::ST_ZDIV : rpn_pkg::ST_UNDER;
            end else begin
              wen_nxt       = 1'b1;
              ncnt_nxt      = pop2_cnt + CW'(1);
              md_ctrl.start = 1'b1;
              md_ctrl.div   = 1'b1;
              if (cmd_r == rpn_pkg::CMD_MOD) begin
                md_ctrl.whole = 1'b1;
                md_opa        = VW'(mag_a[VW-1:F]);
                md_opb        = VW'(mag_b[VW-1:F]);
                mod_nxt       = 1'b1;
                neg_nxt       = a_r[VW-1];
              end
              state_nxt = S_RUN;
            end
          end
          rpn_pkg::CMD_POP: begin
            val_nxt  = b_r;
            ncnt_nxt = pop1_cnt;
            sts_nxt  = has1 ? rpn_pkg::ST_OK : rpn_pkg::ST_UNDER;
          end
          rpn_pkg::CMD_PEEK: begin
            val_nxt = b_r;
            sts_nxt = has1 ? rpn_pkg::ST_OK : rpn_pkg::ST_UNDER;
          end
          rpn_pkg::CMD_SWAP: begin
            if (has2) begin
              // Old second entry goes on top, then the old top below it.
              val_nxt   = a_r;
              wen_nxt   = 1'b1;
              waddr_nxt = top_idx[AW-1:0];
              swap_nxt  = 1'b1;
            end else begin
              val_nxt = b_r;
              sts_nxt = rpn_pkg::ST_SWAP;
            end
          end
          rpn_pkg::CMD_CLEAR: begin
            ncnt_nxt = '0;
          end
          default: begin
          end
        endcase
      end
      S_RUN: begin
        if (md_done) begin
          val_nxt   = fin_val;
          sts_nxt   = under_r ? rpn_pkg::ST_UNDER :
                      (fin_sat ? rpn_pkg::ST_SAT : rpn_pkg::ST_OK);
          state_nxt = S_WR;
        end
      end
      S_WR: begin
        state_nxt = swap_r ? S_WR2 : S_OUT;
      end
      S_WR2: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = val_r;
          out_status_nxt = sts_r;
          out_depth_nxt  = ncnt_r;
          cnt_nxt        = ncnt_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r        <= cmd_nxt;
    opnd_r       <= opnd_nxt;
    b_r          <= b_nxt;
    a_r          <= a_nxt;
    val_r        <= val_nxt;
    sts_r        <= sts_nxt;
    ncnt_r       <= ncnt_nxt;
    wen_r        <= wen_nxt;
    waddr_r      <= waddr_nxt;
    swap_r       <= swap_nxt;
    neg_r        <= neg_nxt;
    mod_r        <= mod_nxt;
    under_r      <= under_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_depth_r  <= out_depth_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({out_depth_r, out_status_r, out_value_r});

  // The depth never exceeds the stack size.
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(STACK_DEPTH))
    else $error("stack depth beyond stack size");

  // The serial unit only finishes while the sequencer waits for it.
  a_md_done: assert property (@(posedge clk) disable iff (!rst_n)
    md_done |-> (state_r == S_RUN))
    else $error("arithmetic unit finished outside its wait state");

  // An accepted transaction always starts with the top-of-stack read.
  a_accept_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_RDB))
    else $error("accepted transaction did not start the read sequence");

  // The stack is only written in the write-back states.
  a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> ((state_r == S_WR) || (state_r == S_WR2)))
    else $error("stack written outside write-back");

endmodule

/* rtl/rpn_stack_mem.sv */
// Operand stack storage for the RPN calculator: one write port and one read
// port with registered read data. Depends on no package.
module rpn_stack_mem #(
  parameter int DEPTH = 128,
  parameter int W     = 32,
  parameter int AW    = 7
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/rpn_muldiv.sv */
// Bit-serial magnitude multiplier and restoring divider for the RPN
// calculator, one result bit per cycle. Depends on rpn_pkg (md_ctrl_t).
module rpn_muldiv #(
  parameter int VW = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rpn_pkg::md_ctrl_t          ctrl,
  input  logic [VW-1:0]              opa,
  input  logic [VW-1:0]              opb,
  output logic                       done,
  output logic [VW+(VW/2)-1:0]       q,
  output logic [VW-1:0]              rem
);

  localparam int F  = VW / 2;
  localparam int QW = VW + F;
  localparam int NW = $clog2(QW + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic          div_r, div_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic [VW:0]   acc_r, acc_nxt;
  logic [QW-1:0] sh_r, sh_nxt;
  logic [VW-1:0] dv_r, dv_nxt;

  logic [VW:0]     sum;
  logic [VW-1:0]   rs;
  logic            ge;
  logic [2*VW-1:0] prod;

  always_comb begin
    sum  = {1'b0, acc_r[VW-1:0]} + (sh_r[0] ? {1'b0, dv_r} : {(VW+1){1'b0}});
    rs   = {acc_r[VW-2:0], sh_r[QW-1]};
    ge   = (rs >= dv_r);
    prod = {acc_r[VW-1:0], sh_r[VW-1:0]};

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    div_nxt  = div_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    sh_nxt   = sh_r;
    dv_nxt   = dv_r;

    if (ctrl.start) begin
      busy_nxt = 1'b1;
      div_nxt  = ctrl.div;
      acc_nxt  = '0;
      if (ctrl.div) begin
        cnt_nxt = NW'(QW);
        dv_nxt  = opb;
        sh_nxt  = ctrl.whole ? QW'(opa) : {opa, {F{1'b0}}};
      end else begin
        cnt_nxt = NW'(VW);
        dv_nxt  = opa;
        sh_nxt  = QW'(opb);
      end
    end else if (busy_r) begin
      if (div_r) begin
        acc_nxt = {1'b0, (ge ? (rs - dv_r) : rs)};
        sh_nxt  = {sh_r[QW-2:0], ge};
      end else begin
        acc_nxt = {1'b0, sum[VW:1]};
        sh_nxt  = QW'({sum[0], sh_r[VW-1:1]});
      end
      cnt_nxt = cnt_r - NW'(1);
      if (cnt_r == NW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    div_r <= div_nxt;
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    sh_r  <= sh_nxt;
    dv_r  <= dv_nxt;
  end

  assign done = done_r;
  assign q    = div_r ? sh_r : prod[2*VW-1:F];
  assign rem  = acc_r[VW-1:0];

endmodule
